// ----- hw/rtl/mscd_pkg.sv -----
package mscd_pkg;

  localparam logic [2:0] REQ_PUSH     = 3'd0;
  localparam logic [2:0] REQ_POP      = 3'd1;
  localparam logic [2:0] REQ_TOP      = 3'd2;
  localparam logic [2:0] REQ_POP_N    = 3'd3;
  localparam logic [2:0] REQ_CLEAR    = 3'd4;
  localparam logic [2:0] REQ_READ_AT  = 3'd5;
  localparam logic [2:0] REQ_WRITE_AT = 3'd6;

  localparam logic CFG_POP_BOTTOM  = 1'b0;
  localparam logic CFG_PUSH_BOTTOM = 1'b1;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
    logic [11:0]        index_or_count;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [10:0]        fill;
    logic               is_empty;
    logic               fault;
  } rsp_t;

endpackage

// ----- hw/rtl/mscd_ram.sv -----
module mscd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/mode_switched_cell_deque.sv -----
// Mode-switched cell deque: a bounded deque of signed cells kept in a
// circular buffer of DEPTH entries; works as stack, queue or inverted stack.
//
// Request channel: cmd is taken at a rising edge with start high and busy
// low. Result channel: rsp is shown for exactly one cycle with rsp_valid
// high; there is no back-pressure, the receiver must take every beat.
// Config: cfg_we/cfg_index/cfg_data write pop_bottom (index 0) and
// push_bottom (index 1); write only while no request is outstanding.
//
// Response path: push, pop_n, clear, write_at and any request that
// needs no cell from storage answer in the cycle after accept, one per cycle while busy is low.
// Pop, top and read_at that return a stored cell go through the cell RAM's
// registered read port: busy is high for one cycle (state S_READ), and the
// result is registered from the RAM output in that state before it is given.
//
// Reset (rst, synchronous) empties the deque, sets the bottom pointer to 0
// and clears both mode bits. The cell RAM is not cleared; only live cells
// are ever read.
module mode_switched_cell_deque
  import mscd_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int CELL_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t cmd,
  output logic rsp_valid,
  output rsp_t rsp,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > 12) ? CW : 12;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic          state;
  logic [AW-1:0] bottom;
  logic [CW-1:0] count;
  logic          pop_bottom;
  logic          push_bottom;

  logic [AW-1:0] bottom_next;
  logic [CW-1:0] count_next;

  logic                 acc;
  logic                 full;
  logic                 arg_lt;
  logic [CW-1:0]        arg_c;
  logic [CW-1:0]        pop_cnt;
  logic [CW-1:0]        cnt_m1;
  logic [CW-1:0]        k_sel;
  logic [CW:0]          sum;
  logic [CW:0]          sum_wrap;
  logic [AW-1:0]        slot;
  logic [AW-1:0]        bot_dec;
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [CELL_BITS-1:0] ram_rdata;
  logic [CELL_BITS-1:0] cell_in;
  logic [31:0]          cell_in_out;
  logic [31:0]          ram_out;
  logic                 need_read;
  logic                 fault_now;
  logic [31:0]          data_now;

  // cell width conversion
  if (CELL_BITS >= 32) begin : g_wide
    assign cell_in     = CELL_BITS'(cmd.value);
    assign cell_in_out = cell_in[31:0];
    assign ram_out     = ram_rdata[31:0];
  end else begin : g_narrow
    assign cell_in     = cmd.value[CELL_BITS-1:0];
    assign cell_in_out = {{(32-CELL_BITS){cell_in[CELL_BITS-1]}}, cell_in};
    assign ram_out     = {{(32-CELL_BITS){ram_rdata[CELL_BITS-1]}}, ram_rdata};
  end

  assign busy   = (state == S_READ);
  assign acc    = start && !busy;
  assign full   = (count == CW'(DEPTH));
  assign arg_lt = IW'(cmd.index_or_count) < IW'(count);
  // only used where the argument is below count, so it fits
  assign arg_c   = CW'(cmd.index_or_count);
  assign pop_cnt = arg_lt ? arg_c : count;
  assign cnt_m1  = count - 1'b1;

  // one shared position adder: slot = (bottom + k) mod DEPTH
  always_comb begin
    unique case (cmd.req_type) inside
      REQ_PUSH:                 k_sel = count;
      REQ_POP, REQ_TOP:         k_sel = pop_bottom ? '0 : cnt_m1;
      REQ_POP_N:                k_sel = pop_cnt;
      REQ_READ_AT, REQ_WRITE_AT: k_sel = pop_bottom ? (cnt_m1 - arg_c) : arg_c;
      default:                  k_sel = '0;
    endcase
  end

  assign sum      = (CW+1)'(bottom) + (CW+1)'(k_sel);
  assign sum_wrap = (sum >= (CW+1)'(DEPTH)) ? (sum - (CW+1)'(DEPTH)) : sum;
  assign slot     = sum_wrap[AW-1:0];
  assign bot_dec  = (bottom == '0) ? AW'(DEPTH - 1) : (bottom - 1'b1);

  always_comb begin
    bottom_next = bottom;
    count_next  = count;
    ram_we      = 1'b0;
    ram_addr    = slot;
    need_read   = 1'b0;
    fault_now   = 1'b0;
    data_now    = '0;
    unique case (cmd.req_type) inside
      REQ_PUSH: begin
        if (full) begin
          fault_now = 1'b1;
        end else begin
          ram_we     = 1'b1;
          data_now   = cell_in_out;
          count_next = count + 1'b1;
          if (push_bottom) begin
            ram_addr    = bot_dec;
            bottom_next = bot_dec;
          end
        end
      end
      REQ_POP, REQ_TOP: begin
        if (count != '0) begin
          need_read = 1'b1;
          if (cmd.req_type == REQ_POP) begin
            count_next = cnt_m1;
            if (pop_bottom) begin
              bottom_next = (bottom == AW'(DEPTH - 1)) ? '0 : (bottom + 1'b1);
            end
          end
        end
      end
      REQ_POP_N: begin
        count_next = count - pop_cnt;
        if (pop_bottom) begin
          bottom_next = slot;
        end
      end
      REQ_CLEAR: begin
        count_next  = '0;
        bottom_next = '0;
      end
      REQ_READ_AT, REQ_WRITE_AT: begin
        if (!arg_lt) begin
          fault_now = 1'b1;
        end else if (cmd.req_type == REQ_WRITE_AT) begin
          ram_we   = 1'b1;
          data_now = cell_in_out;
        end else begin
          need_read = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  mscd_ram #(
    .WIDTH(CELL_BITS),
    .DEPTH(DEPTH)
  ) u_cells (
    .clk  (clk),
    .we   (acc && ram_we),
    .addr (ram_addr),
    .wdata(cell_in),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      bottom      <= '0;
      count       <= '0;
      pop_bottom  <= 1'b0;
      push_bottom <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POP_BOTTOM:  pop_bottom  <= cfg_data;
          CFG_PUSH_BOTTOM: push_bottom <= cfg_data;
          default: begin
          end
        endcase
      end
      rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            bottom <= bottom_next;
            count  <= count_next;
            if (need_read) begin
              state <= S_READ;
            end else begin
              rsp_valid <= 1'b1;
            end
          end
        end
        S_READ: begin
          state     <= S_IDLE;
          rsp_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload; data of a stored-cell read lands in state S_READ, after the other fields
  always_ff @(posedge clk) begin
    if (acc) begin
      rsp.data     <= data_now;
      rsp.fill     <= 11'(count_next);
      rsp.is_empty <= (count_next == '0);
      rsp.fault    <= fault_now;
    end else if (state == S_READ) begin
      rsp.data <= ram_out;
    end
  end

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_read_answers: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> rsp_valid)
    else $error("stored-cell read gave no result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("cell count beyond depth");

  a_bottom_bound: assert property (@(posedge clk) disable iff (rst)
    bottom <= AW'(DEPTH - 1))
    else $error("bottom pointer beyond depth");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.fault) |-> (rsp.data == '0))
    else $error("faulted beat carries data");

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import mscd_pkg::*;

  localparam int DEPTH = 1024;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t cmd = '0;
  logic rsp_valid;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_POP_BOTTOM;
  logic cfg_data = 1'b0;

  mode_switched_cell_deque u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // mirror of the deque contents and modes
  logic signed [31:0] cell_mirror [0:DEPTH-1];
  logic [9:0]  bottom_m = '0;
  logic [10:0] fill_m = '0;
  logic        queue_m = 1'b0;
  logic        invert_m = 1'b0;

  rsp_t awaited_results [$];
  int   mismatches = 0;
  int   send_gap_pct = 0;
  int   stall_cycles = 0;

  function automatic rsp_t deque_step(req_t r);
    rsp_t o;
    logic [11:0] n;
    logic [9:0]  s;
    o = '0;
    case (r.req_type)
      REQ_PUSH: begin
        if (fill_m == DEPTH) begin
          o.fault = 1'b1;
        end else begin
          if (invert_m) begin
            bottom_m = bottom_m - 10'd1;
            s = bottom_m;
          end else begin
            s = bottom_m + fill_m[9:0];
          end
          cell_mirror[s] = r.value;
          fill_m = fill_m + 11'd1;
          o.data = r.value;
        end
      end
      REQ_POP, REQ_TOP: begin
        if (fill_m != 0) begin
          s = queue_m ? bottom_m : bottom_m + fill_m[9:0] - 10'd1;
          o.data = cell_mirror[s];
          if (r.req_type == REQ_POP) begin
            if (queue_m) bottom_m = bottom_m + 10'd1;
            fill_m = fill_m - 11'd1;
          end
        end
      end
      REQ_POP_N: begin
        n = (r.index_or_count < {1'b0, fill_m}) ? r.index_or_count : {1'b0, fill_m};
        if (queue_m) bottom_m = bottom_m + n[9:0];
        fill_m = fill_m - n[10:0];
      end
      REQ_CLEAR: begin
        fill_m = '0;
        bottom_m = '0;
      end
      REQ_READ_AT, REQ_WRITE_AT: begin
        if (r.index_or_count >= {1'b0, fill_m}) begin
          o.fault = 1'b1;
        end else begin
          // queue mode indexes from the top end
          n = queue_m ? {1'b0, fill_m} - 12'd1 - r.index_or_count : r.index_or_count;
          s = bottom_m + n[9:0];
          if (r.req_type == REQ_WRITE_AT) cell_mirror[s] = r.value;
          o.data = cell_mirror[s];
        end
      end
      default: begin
      end
    endcase
    o.fill = fill_m;
    o.is_empty = (fill_m == 0);
    return o;
  endfunction

  function automatic req_t mk(input logic [2:0] op, input logic signed [31:0] val,
                              input logic [11:0] idx);
    req_t r;
    r.req_type = op;
    r.value = val;
    r.index_or_count = idx;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    r.value = $urandom;
    if ($urandom_range(9) == 0) r.value = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    r.index_or_count = 12'($urandom_range(4095));
    if (pick < 35)      r.req_type = REQ_PUSH;
    else if (pick < 50) r.req_type = REQ_POP;
    else if (pick < 60) r.req_type = REQ_TOP;
    else if (pick < 67) r.req_type = REQ_POP_N;
    else if (pick < 69) r.req_type = REQ_CLEAR;
    else if (pick < 82) r.req_type = REQ_READ_AT;
    else if (pick < 95) r.req_type = REQ_WRITE_AT;
    else                r.req_type = REQ_UNUSED;
    // mostly in-range indexes and short pops so the deque keeps some fill
    if (r.req_type == REQ_POP_N && $urandom_range(9) != 0)
      r.index_or_count = 12'($urandom_range(6));
    if ((r.req_type == REQ_READ_AT || r.req_type == REQ_WRITE_AT) && fill_m != 0 &&
        $urandom_range(9) < 8)
      r.index_or_count = 12'($urandom_range(fill_m - 1));
    return r;
  endfunction

  task automatic send_req(input req_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= r;
    do @(posedge clk); while (busy);
    awaited_results.push_back(deque_step(r));
  endtask

  task automatic set_mode(input logic q, input logic inv);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_POP_BOTTOM;
    cfg_data <= q;
    @(posedge clk);
    queue_m = q;
    cfg_index <= CFG_PUSH_BOTTOM;
    cfg_data <= inv;
    @(posedge clk);
    invert_m = inv;
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    send_gap_pct = 0;
    set_mode(1'b0, 1'b0);
    send_req(mk(REQ_TOP, 32'sd5, 12'd0));
    send_req(mk(REQ_POP, 32'sd5, 12'd0));
    send_req(mk(REQ_POP_N, 32'sd0, 12'hFFF));
    send_req(mk(REQ_READ_AT, 32'sd0, 12'd0));
    send_req(mk(REQ_PUSH, 32'sh7FFF_FFFF, 12'd0));
    send_req(mk(REQ_PUSH, 32'sh8000_0000, 12'hFFF));
    send_req(mk(REQ_PUSH, 32'sd0, 12'd0));
    send_req(mk(REQ_PUSH, -32'sd1, 12'h800));
    send_req(mk(REQ_TOP, 32'sd0, 12'd0));
    send_req(mk(REQ_READ_AT, 32'sd0, 12'd0));
    send_req(mk(REQ_READ_AT, 32'sd0, 12'd3));
    send_req(mk(REQ_READ_AT, 32'sd0, 12'd4));
    send_req(mk(REQ_READ_AT, 32'sd0, 12'hFFF));
    send_req(mk(REQ_WRITE_AT, 32'sh1234_5678, 12'd1));
    send_req(mk(REQ_WRITE_AT, 32'sh5555_AAAA, 12'd4));
    send_req(mk(REQ_READ_AT, 32'sd0, 12'd1));
    send_req(mk(REQ_UNUSED, 32'sh0BAD_0BAD, 12'd2));
    send_req(mk(REQ_POP, 32'sd0, 12'd0));
    send_req(mk(REQ_POP_N, 32'sd0, 12'd2));
    send_req(mk(REQ_POP_N, 32'sd0, 12'hFFF));
    send_req(mk(REQ_PUSH, 32'sd77, 12'd0));
    send_req(mk(REQ_CLEAR, 32'sd0, 12'd0));
    send_req(mk(REQ_POP, 32'sd0, 12'd0));
  endtask

  task automatic test_mode_traffic(input int gap_pct, input int n_items);
    for (int m = 0; m < 4; m++) begin
      set_mode(m[0], m[1]);
      send_gap_pct = gap_pct;
      repeat (n_items / 4) send_req(random_req());
    end
  endtask

  always @(posedge clk) begin
    rsp_t exp;
    if (!rst && rsp_valid) begin
      if (awaited_results.size() == 0) begin
        if (mismatches < 10) $display("ERROR: unexpected beat data=%0d fill=%0d", rsp.data,
                                      rsp.fill);
        mismatches++;
      end else begin
        exp = awaited_results.pop_front();
        if (rsp.data !== exp.data || rsp.fill !== exp.fill ||
            rsp.is_empty !== exp.is_empty || rsp.fault !== exp.fault) begin
          if (mismatches < 10)
            $display("ERROR: expected data=%0d fill=%0d empty=%b fault=%b,",
                     exp.data, exp.fill, exp.is_empty, exp.fault,
                     " got data=%0d fill=%0d empty=%b fault=%b",
                     rsp.data, rsp.fill, rsp.is_empty, rsp.fault);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || rsp_valid || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_mode_traffic(10, 316);
    test_mode_traffic(64, 316);
    test_mode_traffic(0, 320);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
